// ----- design/esc_pkg.sv -----
// Package: constants and helpers for the epoch seconds to calendar converter.
`timescale 1ns / 1ps
package esc_pkg;
    // Day numbers run on a March-based four-year cycle starting 1968-03-01
    localparam logic [11:0] CYCLE_BASE_YEAR = 12'd1968;
    localparam logic [15:0] EPOCH_DAY_OFFSET = 16'd671;   // 1968-03-01 to 1970-01-01
    localparam logic [15:0] NO_LEAP_DAY      = 16'd47541; // 2100-03-01, day after 2100-02-28
    localparam logic [15:0] DAYS_CYCLE       = 16'd1461;
    localparam logic [31:0] SECS_DAY         = 32'd86400;

    // Reciprocals for exact constant division over the reachable ranges
    localparam logic [25:0] DAY_RECIP   = 26'd50903317; // ceil(2^35 / 675)
    localparam logic [17:0] MIN_RECIP   = 18'd139811;   // ceil(2^23 / 60)
    localparam logic [11:0] HOUR_RECIP  = 12'd2185;     // ceil(2^17 / 60)
    localparam logic [16:0] CYCLE_RECIP = 17'd91868;    // ceil(2^27 / 1461)

    // Gregorian leap rule for the years this block can reach
    function automatic logic leap_year(input logic [11:0] y);
        logic c;
        c = (y == 12'd2100);
        return (y[1:0] == 2'b00) && !c;
    endfunction

    // Days in month m of year y
    function automatic logic [4:0] month_days(input logic [3:0] m, input logic [11:0] y);
        logic [4:0] r;
        case (m)
            4'd2:                      r = leap_year(y) ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   r = 5'd30;
            default:                   r = 5'd31;
        endcase
        return r;
    endfunction
endpackage

// ----- design/epoch_seconds_to_calendar.sv -----
// Top level: pipelined Unix seconds to UTC calendar date converter.
//   channel | signals                                   | transfer
//   input   | start, busy, timestamp                    | start && !busy
//   result  | done, year, month, day, hour, minute,     | done high, one cycle
//           | second, valid_res                         |
// Six register stages, each at most one multiply deep: whole days,
// seconds of the day and cycle day, minutes and four-year cycle, second, hour
// and cycle remainder, minute and day of year, then month, day and year.
// An input transfer is registered through stages one to five and then into
// done, which is high for one cycle with the result. A new item can enter at
// every edge; busy stays low. Reset clears the valid bits only.
// The receiver cannot stall and the pipeline never needs to.
`timescale 1ns / 1ps
module epoch_seconds_to_calendar (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] timestamp,
    output logic        busy,
    output logic        done,
    output logic [11:0] year,
    output logic [3:0]  month,
    output logic [4:0]  day,
    output logic [4:0]  hour,
    output logic [5:0]  minute,
    output logic [5:0]  second,
    output logic        valid_res
);
    logic        accept;
    logic [50:0] day_prod;
    logic [31:0] day_secs;
    logic [31:0] sod_full;
    logic [34:0] min_prod;
    logic [32:0] cyc_prod;
    logic [16:0] min_secs;
    logic [16:0] sec_full;
    logic [22:0] hr_prod;
    logic [15:0] cyc_days;
    logic [15:0] dc_full;
    logic [10:0] hr_mins;
    logic [10:0] mn_full;
    logic [10:0] doy_full;
    logic [8:0]  mstart;
    logic [8:0]  dom;
    logic        jan_feb;

    logic        v1_reg, v1_next;
    logic [31:0] ts1_reg, ts1_next;
    logic [15:0] days1_reg, days1_next;

    logic        v2_reg, v2_next;
    logic [16:0] sod2_reg, sod2_next;
    logic [15:0] dd2_reg, dd2_next;

    logic        v3_reg, v3_next;
    logic [16:0] sod3_reg, sod3_next;
    logic [10:0] min3_reg, min3_next;
    logic [15:0] dd3_reg, dd3_next;
    logic [5:0]  cyc3_reg, cyc3_next;

    logic        v4_reg, v4_next;
    logic [5:0]  sec4_reg, sec4_next;
    logic [10:0] min4_reg, min4_next;
    logic [4:0]  hour4_reg, hour4_next;
    logic [5:0]  cyc4_reg, cyc4_next;
    logic [10:0] dc4_reg, dc4_next;

    logic        v5_reg, v5_next;
    logic [5:0]  sec5_reg, sec5_next;
    logic [5:0]  minute5_reg, minute5_next;
    logic [4:0]  hour5_reg, hour5_next;
    logic [5:0]  cyc5_reg, cyc5_next;
    logic [1:0]  yic5_reg, yic5_next;
    logic [8:0]  doy5_reg, doy5_next;

    logic        done_reg, done_next;
    logic [11:0] year_reg, year_next;
    logic [3:0]  month_reg, month_next;
    logic [4:0]  day_reg, day_next;
    logic [4:0]  hour_reg, hour_next;
    logic [5:0]  minute_reg, minute_next;
    logic [5:0]  second_reg, second_next;

    assign accept = start && !busy;

    // Stage 1: whole days, ts / 86400 = (ts >> 7) / 675
    always_comb
    begin
        day_prod   = {26'd0, timestamp[31:7]} * {25'd0, esc_pkg::DAY_RECIP};
        v1_next    = accept;
        ts1_next   = timestamp;
        days1_next = day_prod[50:35];
    end

    // Stage 2: seconds into the day; day number on the four-year cycle
    always_comb
    begin
        day_secs  = {16'd0, days1_reg} * esc_pkg::SECS_DAY;
        sod_full  = ts1_reg - day_secs;
        v2_next   = v1_reg;
        sod2_next = sod_full[16:0];
        // 2100 has no leap day: step over the one the cycle would insert
        dd2_next  = days1_reg + esc_pkg::EPOCH_DAY_OFFSET
                    + {15'd0, (days1_reg >= esc_pkg::NO_LEAP_DAY)};
    end

    // Stage 3: minutes of the day and whole four-year cycles
    always_comb
    begin
        min_prod  = {18'd0, sod2_reg} * {17'd0, esc_pkg::MIN_RECIP};
        cyc_prod  = {17'd0, dd2_reg} * {16'd0, esc_pkg::CYCLE_RECIP};
        v3_next   = v2_reg;
        sod3_next = sod2_reg;
        min3_next = min_prod[33:23];
        dd3_next  = dd2_reg;
        cyc3_next = cyc_prod[32:27];
    end

    // Stage 4: second, hour and day within the cycle
    always_comb
    begin
        min_secs   = {6'd0, min3_reg} * 17'd60;
        sec_full   = sod3_reg - min_secs;
        hr_prod    = {12'd0, min3_reg} * {11'd0, esc_pkg::HOUR_RECIP};
        cyc_days   = {10'd0, cyc3_reg} * esc_pkg::DAYS_CYCLE;
        dc_full    = dd3_reg - cyc_days;
        v4_next    = v3_reg;
        sec4_next  = sec_full[5:0];
        min4_next  = min3_reg;
        hour4_next = hr_prod[21:17];
        cyc4_next  = cyc3_reg;
        dc4_next   = dc_full[10:0];
    end

    // Stage 5: minute of the hour; year in the cycle and day of that year
    always_comb
    begin
        hr_mins      = {6'd0, hour4_reg} * 11'd60;
        mn_full      = min4_reg - hr_mins;
        v5_next      = v4_reg;
        sec5_next    = sec4_reg;
        minute5_next = mn_full[5:0];
        hour5_next   = hour4_reg;
        cyc5_next    = cyc4_reg;
        // last year of the cycle keeps the leap day at its end
        if (dc4_reg >= 11'd1095)
        begin
            yic5_next = 2'd3;
            doy_full  = dc4_reg - 11'd1095;
        end
        else if (dc4_reg >= 11'd730)
        begin
            yic5_next = 2'd2;
            doy_full  = dc4_reg - 11'd730;
        end
        else if (dc4_reg >= 11'd365)
        begin
            yic5_next = 2'd1;
            doy_full  = dc4_reg - 11'd365;
        end
        else
        begin
            yic5_next = 2'd0;
            doy_full  = dc4_reg;
        end
        doy5_next = doy_full[8:0];
    end

    // Stage 6: month and day from a March-based day of year, then the year
    always_comb
    begin
        jan_feb = 1'b0;
        if (doy5_reg >= 9'd337)
        begin
            month_next = 4'd2;
            mstart     = 9'd337;
            jan_feb    = 1'b1;
        end
        else if (doy5_reg >= 9'd306)
        begin
            month_next = 4'd1;
            mstart     = 9'd306;
            jan_feb    = 1'b1;
        end
        else if (doy5_reg >= 9'd275)
        begin
            month_next = 4'd12;
            mstart     = 9'd275;
        end
        else if (doy5_reg >= 9'd245)
        begin
            month_next = 4'd11;
            mstart     = 9'd245;
        end
        else if (doy5_reg >= 9'd214)
        begin
            month_next = 4'd10;
            mstart     = 9'd214;
        end
        else if (doy5_reg >= 9'd184)
        begin
            month_next = 4'd9;
            mstart     = 9'd184;
        end
        else if (doy5_reg >= 9'd153)
        begin
            month_next = 4'd8;
            mstart     = 9'd153;
        end
        else if (doy5_reg >= 9'd122)
        begin
            month_next = 4'd7;
            mstart     = 9'd122;
        end
        else if (doy5_reg >= 9'd92)
        begin
            month_next = 4'd6;
            mstart     = 9'd92;
        end
        else if (doy5_reg >= 9'd61)
        begin
            month_next = 4'd5;
            mstart     = 9'd61;
        end
        else if (doy5_reg >= 9'd31)
        begin
            month_next = 4'd4;
            mstart     = 9'd31;
        end
        else
        begin
            month_next = 4'd3;
            mstart     = 9'd0;
        end
        dom         = doy5_reg - mstart + 9'd1;
        day_next    = dom[4:0];
        // January and February belong to the next calendar year
        year_next   = esc_pkg::CYCLE_BASE_YEAR + {4'd0, cyc5_reg, yic5_reg}
                      + {11'd0, jan_feb};
        hour_next   = hour5_reg;
        minute_next = minute5_reg;
        second_next = sec5_reg;
        done_next   = v5_reg;
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            v5_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= v1_next;
            v2_reg   <= v2_next;
            v3_reg   <= v3_next;
            v4_reg   <= v4_next;
            v5_reg   <= v5_next;
            done_reg <= done_next;
        end
    end

    // Stage data
    always_ff @(posedge clk)
    begin
        ts1_reg     <= ts1_next;
        days1_reg   <= days1_next;
        sod2_reg    <= sod2_next;
        dd2_reg     <= dd2_next;
        sod3_reg    <= sod3_next;
        min3_reg    <= min3_next;
        dd3_reg     <= dd3_next;
        cyc3_reg    <= cyc3_next;
        sec4_reg    <= sec4_next;
        min4_reg    <= min4_next;
        hour4_reg   <= hour4_next;
        cyc4_reg    <= cyc4_next;
        dc4_reg     <= dc4_next;
        sec5_reg    <= sec5_next;
        minute5_reg <= minute5_next;
        hour5_reg   <= hour5_next;
        cyc5_reg    <= cyc5_next;
        yic5_reg    <= yic5_next;
        doy5_reg    <= doy5_next;
        year_reg    <= year_next;
        month_reg   <= month_next;
        day_reg     <= day_next;
        hour_reg    <= hour_next;
        minute_reg  <= minute_next;
        second_reg  <= second_next;
    end

    // Result ports; the pipeline never refuses input
    assign busy      = 1'b0;
    assign done      = done_reg;
    assign year      = year_reg;
    assign month     = month_reg;
    assign day       = day_reg;
    assign hour      = hour_reg;
    assign minute    = minute_reg;
    assign second    = second_reg;
    assign valid_res = (second_reg <= 6'd59) && (minute_reg <= 6'd59) && (hour_reg <= 5'd23)
                       && (month_reg <= 4'd12)
                       && (day_reg <= esc_pkg::month_days(month_reg, year_reg));
endmodule

// ----- sim/tb.sv -----
// Testbench: directed and random checks of the epoch seconds to calendar converter.
`timescale 1ns / 1ps
module tb;
    logic        clk;
    logic        rst_n;
    logic        start;
    logic [31:0] timestamp;
    logic        busy;
    logic        done;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic        valid_res;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic        ok;
    } utc_date_t;

    logic [31:0] stamp_q[$];
    utc_date_t   date_q[$];
    int          errors;
    int          checked;
    int          gap;
    bit          drain_req;

    epoch_seconds_to_calendar uut (
        .clk(clk), .rst_n(rst_n), .start(start), .timestamp(timestamp),
        .busy(busy), .done(done), .year(year), .month(month), .day(day),
        .hour(hour), .minute(minute), .second(second), .valid_res(valid_res)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Gregorian leap rule, full form
    function automatic bit is_leap(int unsigned y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic int unsigned days_in(int unsigned m, int unsigned y);
        int unsigned lens[12];
        lens = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
        if (m == 2) return is_leap(y) ? 29 : 28;
        return lens[m - 1];
    endfunction

    // Calendar breakdown of a seconds count: years, then months, then units
    function automatic utc_date_t to_calendar(logic [31:0] secs);
        utc_date_t   r;
        int unsigned rest;
        int unsigned y;
        int unsigned m;
        int unsigned span;
        int unsigned d;
        int unsigned h;
        int unsigned mi;
        int unsigned sc;
        rest = secs;
        y = 1970;
        m = 1;
        forever
        begin
            span = is_leap(y) ? 31622400 : 31536000;
            if (span > rest) break;
            rest -= span;
            y++;
        end
        while (m < 12)
        begin
            span = days_in(m, y) * 86400;
            if (span > rest) break;
            rest -= span;
            m++;
        end
        d = rest / 86400 + 1;
        rest = rest % 86400;
        h = rest / 3600;
        mi = (rest % 3600) / 60;
        sc = rest % 60;
        r.year   = y[11:0];
        r.month  = m[3:0];
        r.day    = d[4:0];
        r.hour   = h[4:0];
        r.minute = mi[5:0];
        r.second = sc[5:0];
        r.ok     = (d <= days_in(m, y));
        return r;
    endfunction

    function automatic int pick_gap();
        if ($urandom_range(0, 9) < 4) return 0;
        if ($urandom_range(0, 9) < 9) return $urandom_range(1, 4);
        return $urandom_range(20, 300);
    endfunction

    // Driver: one transfer per start && !busy edge
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start     <= 1'b0;
            timestamp <= '0;
            gap       <= 0;
        end
        else if (start && !busy)
        begin
            // transfer taken at the last rising edge
            date_q.push_back(to_calendar(timestamp));
            void'(stamp_q.pop_front());
            gap <= pick_gap();
            if (gap == 0 && stamp_q.size() > 0 && !drain_req)
                timestamp <= stamp_q[0];
            else
                start <= 1'b0;
        end
        else if (!start)
        begin
            if (gap > 0)
                gap <= gap - 1;
            else if (stamp_q.size() > 0 && !(drain_req && date_q.size() > 0))
            begin
                start     <= 1'b1;
                timestamp <= stamp_q[0];
            end
        end
    end

    // Monitor: compare each done strobe with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (date_q.size() == 0)
            begin
                $error("result with nothing expected");
                errors++;
            end
            else
            begin
                if (date_q[0].year !== year)
                    begin $error("year exp %0d got %0d", date_q[0].year, year); errors++; end
                if (date_q[0].month !== month)
                    begin $error("month exp %0d got %0d", date_q[0].month, month); errors++; end
                if (date_q[0].day !== day)
                    begin $error("day exp %0d got %0d", date_q[0].day, day); errors++; end
                if (date_q[0].hour !== hour)
                    begin $error("hour exp %0d got %0d", date_q[0].hour, hour); errors++; end
                if (date_q[0].minute !== minute)
                    begin $error("minute exp %0d got %0d", date_q[0].minute, minute); errors++; end
                if (date_q[0].second !== second)
                    begin $error("second exp %0d got %0d", date_q[0].second, second); errors++; end
                if (date_q[0].ok !== valid_res)
                    begin $error("valid_res exp %0d got %0d", date_q[0].ok, valid_res); errors++; end
                void'(date_q.pop_front());
                checked++;
            end
        end
    end

    initial
    begin
        logic [31:0] base;
        int unsigned yr;
        errors = 0;
        checked = 0;
        drain_req = 0;
        rst_n = 1'b0;
        start = 1'b0;
        timestamp = '0;
        // directed: extremes, year/month/leap boundaries, 2100 non-leap, 2000 leap
        stamp_q.push_back(32'd0);
        stamp_q.push_back(32'hFFFF_FFFF);
        stamp_q.push_back(32'd31535999);
        stamp_q.push_back(32'd31536000);
        stamp_q.push_back(32'd68169599);  // 1972-02-28 23:59:59
        stamp_q.push_back(32'd68169600);  // 1972-02-29
        stamp_q.push_back(32'd951782399); // 2000-02-28 23:59:59
        stamp_q.push_back(32'd951868799); // 2000-02-29 23:59:59
        stamp_q.push_back(32'd978307199); // 2000-12-31 23:59:59
        stamp_q.push_back(32'd4107542399); // 2100-02-28 23:59:59
        stamp_q.push_back(32'd4107542400); // 2100-03-01
        stamp_q.push_back(32'd4102444799); // 2099-12-31 23:59:59
        stamp_q.push_back(32'h8000_0000);
        stamp_q.push_back(32'h7FFF_FFFF);
        stamp_q.push_back(32'hAAAA_AAAA);
        stamp_q.push_back(32'h5555_5555);
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        // hold off until the directed set has fully drained
        wait (stamp_q.size() == 0 && date_q.size() == 0);
        drain_req = 1;
        for (int i = 0; i < 1100; i++)
        begin
            case ($urandom_range(0, 3))
                0: stamp_q.push_back($urandom);
                1: stamp_q.push_back($urandom_range(0, 400) * 32'd86400
                                     + $urandom_range(0, 1) * 32'd86399);
                2:
                begin
                    // near a year start, within five seconds either side; for 2106 up to 3000000 s after it
                    yr = $urandom_range(1971, 2106);
                    base = 0;
                    for (int unsigned k = 1970; k < yr; k++)
                        base += is_leap(k) ? 32'd31622400 : 32'd31536000;
                    if (yr == 2106) base = base + $urandom_range(0, 3000000);
                    else base = base - 5 + $urandom_range(0, 10);
                    stamp_q.push_back(base);
                end
                default: stamp_q.push_back(32'hFFFF_FFFF - $urandom_range(0, 1000000));
            endcase
            if (i == 10)
            begin
                // sender pauses until all results are back
                wait (date_q.size() == 0 && stamp_q.size() == 0);
                drain_req = 0;
            end
        end
        wait (stamp_q.size() == 0 && !start);
        wait (date_q.size() == 0);
        repeat (300) @(posedge clk);
        $display("Checked %0d conversions: epoch extremes, leap and century edges,", checked);
        $display("year and day boundaries, random stamps with random input gaps.");
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("DONE: errors detected");
        $finish;
    end
endmodule

// ----- epoch_seconds_to_calendar.f -----
design/esc_pkg.sv
design/epoch_seconds_to_calendar.sv
sim/tb.sv
